>>> sv/ics_pkg.sv
// Shared types, codes and the one's-complement fold for the Internet checksum block.
package ics_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST  = 2'd2;

    localparam logic [1:0] MODE_IP  = 2'd0;
    localparam logic [1:0] MODE_UDP = 2'd1;
    localparam logic [1:0] MODE_TCP = 2'd2;

    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_TCP = 8'd6;

    localparam logic [15:0] UDP_ZERO_SUM = 16'hffff;

    // One queue entry: a finished 16-bit word and, on the final word of a
    // packet, the folded pseudo-header contribution.
    typedef struct packed {
        logic [15:0] word;
        logic [15:0] extra;
        logic        last;
        logic        udp;
    } t_entry;

    // Folds a wide raw sum to 16 bits with end-around carry. The result is
    // zero only when the raw sum is zero.
    function automatic logic [15:0] oc_fold(input logic [20:0] v);
        logic [16:0] s1;
        s1 = {1'b0, v[15:0]} + {12'd0, v[20:16]};
        return s1[15:0] + {15'd0, s1[16]};
    endfunction

endpackage

>>> sv/ics_intf.sv
// Channel interfaces of the checksum block: byte stream, result stream, configuration writes.
interface ics_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ics_sum_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;
    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

interface ics_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/ics_front.sv
// Front end: configuration registers, byte pairing, byte count and pseudo-header folding.
module ics_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ics_byte_if.sink       i_byte,
    ics_cfg_if.sink        i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output ics_pkg::t_entry o_entry
);
    import ics_pkg::*;

    logic [1:0]  r_mode;
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic [18:0] r_pseudo;
    logic [18:0] n_pseudo;
    logic [7:0]  r_high;
    logic        r_pending;
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic        r_cfg_hold;
    logic [19:0] w_raw;
    logic        w_accept;
    logic        w_ph;
    logic [7:0]  w_proto;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = !i_full && !r_cfg_hold;
    assign w_accept     = i_byte.valid && !i_full && !r_cfg_hold;

    assign w_ph    = (r_mode == MODE_UDP) || (r_mode == MODE_TCP);
    assign w_proto = (r_mode == MODE_UDP) ? PROTO_UDP : PROTO_TCP;
    assign n_pseudo = {3'd0, r_src[31:16]} + {3'd0, r_src[15:0]}
                    + {3'd0, r_dst[31:16]} + {3'd0, r_dst[15:0]} + {11'd0, w_proto};

    assign n_count = r_count + 16'd1;
    assign w_raw   = {1'b0, r_pseudo} + {4'd0, n_count};

    always_comb begin
        o_push        = w_accept && (r_pending || i_byte.last_byte);
        o_entry.word  = r_pending ? {r_high, i_byte.data_byte} : {i_byte.data_byte, 8'd0};
        o_entry.extra = (w_ph && i_byte.last_byte) ? oc_fold({1'b0, w_raw}) : 16'd0;
        o_entry.last  = i_byte.last_byte;
        o_entry.udp   = (r_mode == MODE_UDP);
    end

    always_ff @(posedge i_clk) begin
        // The pseudo-header sum is registered from the configuration registers, so
        // the byte input is held off for the cycle after each write.
        r_pseudo <= n_pseudo;
        if (w_accept && !r_pending) begin
            r_high <= i_byte.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IP;
            r_src      <= 32'd0;
            r_dst      <= 32'd0;
            r_pending  <= 1'b0;
            r_count    <= 16'd0;
            r_cfg_hold <= 1'b0;
        end else begin
            r_cfg_hold <= i_cfg.valid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_MODE: r_mode <= i_cfg.data[1:0];
                    CFG_SRC:  r_src  <= i_cfg.data;
                    CFG_DST:  r_dst  <= i_cfg.data;
                    default:  ;
                endcase
            end
            if (w_accept) begin
                if (i_byte.last_byte) begin
                    r_pending <= 1'b0;
                    r_count   <= 16'd0;
                end else begin
                    r_pending <= !r_pending;
                    r_count   <= n_count;
                end
            end
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_byte.last_byte) |=> (!r_pending && r_count == 16'd0))
        else $error("front state not cleared after the last item of a packet");

endmodule

>>> sv/ics_fifo.sv
// Short register queue of finished words between the front and back ends.
module ics_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ics_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ics_pkg::t_entry o_head
);
    import ics_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue fill count beyond its depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue fill count missed a push");

endmodule

>>> sv/ics_back.sv
// Back end: one's-complement accumulator and the registered checksum output.
module ics_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  ics_pkg::t_entry i_head,
    output logic            o_pop,
    ics_sum_if.source       o_sum
);
    import ics_pkg::*;

    logic [15:0] r_sum;
    logic        r_out_valid;
    logic [15:0] r_checksum;
    logic [17:0] w_raw;
    logic [15:0] w_sum;
    logic [15:0] w_result;

    assign o_sum.valid    = r_out_valid;
    assign o_sum.checksum = r_checksum;

    // Plain words never wait; the final word waits only for a free output.
    assign o_pop = !i_empty && (!i_head.last || !r_out_valid || o_sum.ready);

    assign w_raw    = {2'd0, r_sum} + {2'd0, i_head.word} + {2'd0, i_head.extra};
    assign w_sum    = oc_fold({3'd0, w_raw});
    assign w_result = (i_head.udp && w_sum == 16'hffff) ? UDP_ZERO_SUM : ~w_sum;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_checksum <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_sum <= i_head.last ? 16'd0 : w_sum;
            end
            if (o_pop && i_head.last) begin
                r_out_valid <= 1'b1;
            end else if (o_sum.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_final_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_pop && i_head.last)) |-> (r_out_valid && r_sum == 16'd0))
        else $error("final word did not load the output and clear the sum");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(o_pop && i_head.last))
        else $error("checksum shown without a final word");

endmodule

>>> sv/internet_checksum_ip_udp_tcp.sv
// Top level of the Internet checksum block for IPv4 headers, UDP and TCP.
//
// The block takes a packet one byte per item, in wire order, with last_byte
// set on the final byte, and returns one 16-bit checksum per packet: the
// complement of the one's-complement sum of the big-endian 16-bit words,
// an odd final byte padded with a zero low byte. In UDP and TCP modes the
// IPv4 pseudo-header (both configured addresses, protocol 17 or 6 and the
// byte count modulo 65536) is included, and in UDP mode a zero result is
// sent as 0xffff. Configuration register 0 selects the mode (0 IP header
// only, 1 UDP, 2 TCP, 3 behaves as 0), register 1 holds the source address
// and register 2 the destination address; writes are taken in any cycle and
// must be made between packets, and the byte input pauses for the cycle
// after each write while the pseudo-header term is rebuilt. One byte is
// accepted every clock cycle, outside those pauses, while the queue
// between the front and back ends has room; the checksum is loaded into
// the output register when the back end pops the final word. The back
// end folds one word per cycle into its 16-bit one's-complement sum,
// end-around carry included, while words are queued, and the front end
// pairs bytes and prepares the pseudo-header term in parallel. A stalled
// output holds only the final word of the next packet; plain words keep
// draining, so the next packet can stream in behind a result that waits.
module internet_checksum_ip_udp_tcp #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ics_byte_if.sink  i_byte,
    ics_cfg_if.sink   i_cfg,
    ics_sum_if.source o_sum
);
    import ics_pkg::*;

    t_entry w_push_entry;
    t_entry w_head;
    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;

    // Front end: pairs bytes into words and, in UDP and TCP modes, adds the
    // pseudo-header term to the final word of each packet.
    ics_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // Queue of finished words, so that each side can stall on its own.
    ics_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // Back end: accumulates words and registers the finished checksum.
    ics_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_sum   (o_sum)
    );

endmodule
